/* rtl/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types, codes and parameter defaults of the bitmap frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

  localparam int FRAMES_DEF          = 65536;
  localparam int RESERVED_FRAMES_DEF = 1280;
  localparam int FRAME_BYTES_DEF     = 4096;
  localparam int WORD_BITS_DEF       = 64;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_MARK  = 2'd2,
    REQ_QUERY = 2'd3
  } req_t;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_A_SUM,
    ST_A_WORD,
    ST_F_WORD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    req_t        req_type;
    logic [15:0] frame_index;
    logic [31:0] free_address;
  } req_item_t;

  typedef struct packed {
    logic [31:0] alloc_address;
    logic        frame_free_flag;
    logic [1:0]  status;
    logic [16:0] used_count;
  } res_item_t;

endpackage

`default_nettype wire

/* rtl/bfa_stream_if.sv */
// ----------------------------------------------------------------------------
// bfa_stream_if
// Valid/ready channel carrying one payload item per accepted transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/bfa_ram.sv */
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ram #(
  parameter  int WIDTH = 64,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/bitmap_frame_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit page-frame allocator over a usage bitmap held in RAM, with a
// summary RAM of full words and a flop vector of full summary words.
// ----------------------------------------------------------------------------
// a request is taken only in idle, so one is in flight at a time; an alloc does the
//   dependent summary read then bitmap word read, free/mark/query read the word and
//   its summary word together, and out-of-range or allocator-full requests go
//   straight to the result
// reset: a clearing pass of one bitmap word per cycle writes the reserved pattern
//   before the first request is taken
`default_nettype none

module bitmap_frame_allocator #(
  parameter int FRAMES          = bfa_pkg::FRAMES_DEF,
  parameter int RESERVED_FRAMES = bfa_pkg::RESERVED_FRAMES_DEF,
  parameter int FRAME_BYTES     = bfa_pkg::FRAME_BYTES_DEF,
  parameter int WORD_BITS       = bfa_pkg::WORD_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  bfa_stream_if.sink   request,
  bfa_stream_if.source result
);

  import bfa_pkg::*;

  localparam int W      = WORD_BITS;
  localparam int LW     = $clog2(W);
  localparam int FS     = $clog2(FRAME_BYTES);
  localparam int NWORDS = (FRAMES + W - 1) / W;
  localparam int NSUM   = (NWORDS + W - 1) / W;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int SW     = (NSUM > 1) ? $clog2(NSUM) : 1;
  localparam int FXW    = AW + LW;
  localparam int UW     = $clog2(FRAMES + 1);
  localparam int R_EFF  = (RESERVED_FRAMES > FRAMES) ? FRAMES : RESERVED_FRAMES;

  // word full at reset; bits past the last frame are stored as used
  function automatic logic word_full_rst(input int w);
    int hi;
    begin
      hi = ((w + 1) * W > FRAMES) ? FRAMES : (w + 1) * W;
      return (w >= NWORDS) || (hi <= R_EFF);
    end
  endfunction

  function automatic logic top_full_rst(input int s);
    int last;
    begin
      last = (((s + 1) * W > NWORDS) ? NWORDS : (s + 1) * W) - 1;
      return word_full_rst(last);
    end
  endfunction

  function automatic logic [LW-1:0] first_zero(input logic [W-1:0] v);
    logic [LW-1:0] r;
    begin
      r = '0;
      for (int i = W - 1; i >= 0; i--) begin
        if (!v[i]) r = LW'(i);
      end
      return r;
    end
  endfunction

  state_t state, state_next;

  req_t            req_q, req_next;
  logic [FXW-1:0]  frm, frm_next;
  logic [SW-1:0]   sidx, sidx_next;
  logic [LW-1:0]   jidx, jidx_next;
  logic [AW-1:0]   wsel, wsel_next;
  logic [AW-1:0]   cnt, cnt_next;
  logic [UW-1:0]   used_total, used_total_next;
  logic [NSUM-1:0] top, top_next;
  logic [31:0]     res_addr, res_addr_next;
  logic            res_flag, res_flag_next;
  logic [1:0]      res_status, res_status_next;

  res_item_t out_data;
  logic      out_valid;
  logic      out_load;

  logic          bm_we, bm_re, sm_we, sm_re;
  logic [AW-1:0] bm_waddr, bm_raddr;
  logic [SW-1:0] sm_waddr, sm_raddr;
  logic [W-1:0]  bm_wdata, bm_rdata, sm_wdata, sm_rdata;

  bfa_ram #(.WIDTH(W), .DEPTH(NWORDS)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (bm_re),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  bfa_ram #(.WIDTH(W), .DEPTH(NSUM)) u_summary (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .re    (sm_re),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  // request decode
  logic [31:0]      fcand;
  logic             in_range;
  logic [FXW-1:0]   frm_in;
  logic [SW+LW-1:0] wx_in;
  logic [SW-1:0]    s0;
  logic             top_full;

  always_comb begin
    fcand    = (request.data.req_type == REQ_FREE) ? (request.data.free_address >> FS)
                                                   : 32'(request.data.frame_index);
    in_range = fcand < 32'(FRAMES);
    frm_in   = FXW'(fcand);
    wx_in    = (SW + LW)'(frm_in[FXW-1:LW]);
    top_full = &top;
    s0       = '0;
    for (int i = NSUM - 1; i >= 0; i--) begin
      if (!top[i]) s0 = SW'(i);
    end
  end

  // reset pattern for the clearing pass
  logic [W-1:0]  clr_bm, clr_sm;
  logic [SW-1:0] cnt_s;
  logic [31:0]   clr_f, clr_w;

  always_comb begin
    cnt_s = SW'(cnt);
    clr_f = '0;
    clr_w = '0;
    for (int b = 0; b < W; b++) begin
      clr_f     = 32'({cnt, LW'(b)});
      clr_bm[b] = (clr_f < 32'(R_EFF)) || (clr_f >= 32'(FRAMES));
    end
    for (int j = 0; j < W; j++) begin
      clr_w     = 32'({cnt_s, LW'(j)});
      clr_sm[j] = (clr_w >= 32'(NWORDS)) || (((clr_w + 32'd1) << LW) <= 32'(R_EFF))
                  || (FRAMES <= R_EFF);
    end
  end

  // word and summary updates
  logic [LW-1:0] bsel, b0;
  logic          bit_used;
  logic [W-1:0]  alloc_word, mark_word, free_word;
  logic [W-1:0]  sum_set, sum_clr;

  always_comb begin
    bsel       = frm[LW-1:0];
    bit_used   = bm_rdata[bsel];
    b0         = first_zero(bm_rdata);
    alloc_word = bm_rdata | (W'(1) << b0);
    mark_word  = bm_rdata | (W'(1) << bsel);
    free_word  = bm_rdata & ~(W'(1) << bsel);
    sum_set    = sm_rdata | (W'(1) << jidx);
    sum_clr    = sm_rdata & ~(W'(1) << jidx);
  end

  assign request.ready = (state == ST_IDLE);
  assign out_load      = (state == ST_EMIT) && (!out_valid || result.ready);

  always_comb begin
    state_next      = state;
    req_next        = req_q;
    frm_next        = frm;
    sidx_next       = sidx;
    jidx_next       = jidx;
    wsel_next       = wsel;
    cnt_next        = cnt;
    used_total_next = used_total;
    top_next        = top;
    res_addr_next   = res_addr;
    res_flag_next   = res_flag;
    res_status_next = res_status;
    bm_re           = 1'b0;
    bm_raddr        = wsel;
    sm_re           = 1'b0;
    sm_raddr        = sidx;
    bm_we           = 1'b0;
    bm_waddr        = wsel;
    bm_wdata        = bm_rdata;
    sm_we           = 1'b0;
    sm_waddr        = sidx;
    sm_wdata        = sm_rdata;

    case (state)
      ST_CLR: begin
        bm_we    = 1'b1;
        bm_waddr = cnt;
        bm_wdata = clr_bm;
        sm_we    = 32'(cnt) < 32'(NSUM);
        sm_waddr = cnt_s;
        sm_wdata = clr_sm;
        cnt_next = cnt + AW'(1);
        if (cnt == AW'(NWORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (request.valid) begin
          req_next        = request.data.req_type;
          res_addr_next   = '0;
          res_flag_next   = 1'b0;
          res_status_next = STATUS_OK;
          if (request.data.req_type == REQ_ALLOC) begin
            if (top_full) begin
              res_status_next = STATUS_NO_FREE;
              state_next      = ST_EMIT;
            end else begin
              sidx_next  = s0;
              sm_re      = 1'b1;
              sm_raddr   = s0;
              state_next = ST_A_SUM;
            end
          end else if (!in_range) begin
            res_status_next = STATUS_RANGE;
            state_next      = ST_EMIT;
          end else begin
            // fetch the word and its summary word together
            frm_next   = frm_in;
            wsel_next  = frm_in[FXW-1:LW];
            sidx_next  = wx_in[SW+LW-1:LW];
            jidx_next  = wx_in[LW-1:0];
            bm_re      = 1'b1;
            bm_raddr   = frm_in[FXW-1:LW];
            sm_re      = 1'b1;
            sm_raddr   = wx_in[SW+LW-1:LW];
            state_next = ST_F_WORD;
          end
        end
      end

      ST_A_SUM: begin
        jidx_next  = first_zero(sm_rdata);
        wsel_next  = AW'({sidx, first_zero(sm_rdata)});
        bm_re      = 1'b1;
        bm_raddr   = AW'({sidx, first_zero(sm_rdata)});
        state_next = ST_A_WORD;
      end

      ST_A_WORD: begin
        bm_we           = 1'b1;
        bm_wdata        = alloc_word;
        used_total_next = used_total + UW'(1);
        res_addr_next   = 32'(64'({sidx, jidx, b0}) << FS);
        if (&alloc_word) begin
          sm_we    = 1'b1;
          sm_wdata = sum_set;
          if (&sum_set) top_next[sidx] = 1'b1;
        end
        state_next = ST_EMIT;
      end

      ST_F_WORD: begin
        case (req_q)
          REQ_QUERY: begin
            res_flag_next = !bit_used;
          end
          REQ_FREE: begin
            if (bit_used) begin
              bm_we           = 1'b1;
              bm_wdata        = free_word;
              sm_we           = 1'b1;
              sm_wdata        = sum_clr;
              top_next[sidx]  = 1'b0;
              used_total_next = used_total - UW'(1);
            end
          end
          REQ_MARK: begin
            if (!bit_used) begin
              bm_we           = 1'b1;
              bm_wdata        = mark_word;
              used_total_next = used_total + UW'(1);
              if (&mark_word) begin
                sm_we    = 1'b1;
                sm_wdata = sum_set;
                if (&sum_set) top_next[sidx] = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_load) state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      used_total <= UW'(R_EFF);
      out_valid  <= 1'b0;
      for (int s = 0; s < NSUM; s++) begin
        top[s] <= top_full_rst(s);
      end
    end else begin
      cnt        <= cnt_next;
      used_total <= used_total_next;
      top        <= top_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_q      <= req_next;
    frm        <= frm_next;
    sidx       <= sidx_next;
    jidx       <= jidx_next;
    wsel       <= wsel_next;
    res_addr   <= res_addr_next;
    res_flag   <= res_flag_next;
    res_status <= res_status_next;
    if (out_load) begin
      out_data.alloc_address   <= res_addr;
      out_data.frame_free_flag <= res_flag;
      out_data.status          <= res_status;
      out_data.used_count      <= 17'(used_total);
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

`default_nettype wire

/* test/bitmap_frame_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_tb
// Runs allocate, free, mark and query requests through the frame allocator.
// A directed table covers the corners first, and some rows carry their answer
// typed in. Two rounds of a random mix follow. The rows with no typed answer,
// and every random request, are checked against a shadow copy of the usage
// bitmap kept here.
// ----------------------------------------------------------------------------

module bitmap_frame_allocator_tb;
  import bfa_pkg::*;

  localparam int FRAMES          = FRAMES_DEF;
  localparam int RESERVED_FRAMES = RESERVED_FRAMES_DEF;
  localparam int FRAME_BYTES     = FRAME_BYTES_DEF;
  localparam int WORD_BITS       = WORD_BITS_DEF;
  localparam int NWORDS          = (FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int CYCLE_LIMIT     = 400_000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int RANDOM_ITEMS    = 640;

  typedef struct packed {
    req_t        kind;
    logic [15:0] idx;
    logic [31:0] addr;
    logic        typed;
    res_item_t   want;
  } dir_row_t;

  // reset leaves frames 0..1279 used, 1280 onward free
  dir_row_t dir_rows [0:20] = '{
    {REQ_QUERY, 16'd0,     32'h0000_0000, 1'b1, 32'h0, 1'b0, STATUS_OK,    17'd1280},
    {REQ_QUERY, 16'd1279,  32'h0000_0000, 1'b1, 32'h0, 1'b0, STATUS_OK,    17'd1280},
    {REQ_QUERY, 16'd1280,  32'h0000_0000, 1'b1, 32'h0, 1'b1, STATUS_OK,    17'd1280},
    {REQ_QUERY, 16'hFFFF,  32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1, STATUS_OK,    17'd1280},
    {REQ_ALLOC, 16'hFFFF,  32'hFFFF_FFFF, 1'b1, 32'h0050_0000, 1'b0, STATUS_OK, 17'd1281},
    {REQ_FREE,  16'h0000,  32'h0050_0FFF, 1'b1, 32'h0, 1'b0, STATUS_OK,    17'd1280},
    {REQ_FREE,  16'h0000,  32'h0050_0000, 1'b1, 32'h0, 1'b0, STATUS_OK,    17'd1280},
    {REQ_MARK,  16'd1280,  32'h0000_0000, 1'b1, 32'h0, 1'b0, STATUS_OK,    17'd1281},
    {REQ_MARK,  16'd1280,  32'h0000_0000, 1'b1, 32'h0, 1'b0, STATUS_OK,    17'd1281},
    {REQ_FREE,  16'h0000,  32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, STATUS_RANGE, 17'd1281},
    {REQ_FREE,  16'h0000,  32'h1000_0000, 1'b1, 32'h0, 1'b0, STATUS_RANGE, 17'd1281},
    {REQ_FREE,  16'hFFFF,  32'h0FFF_FFFF, 1'b0, 52'h0},
    {REQ_MARK,  16'hFFFF,  32'h0000_0000, 1'b1, 32'h0, 1'b0, STATUS_OK,    17'd1282},
    {REQ_QUERY, 16'hFFFF,  32'h0000_0000, 1'b0, 52'h0},
    {REQ_FREE,  16'h0000,  32'h0000_0ABC, 1'b1, 32'h0, 1'b0, STATUS_OK,    17'd1281},
    {REQ_ALLOC, 16'h0000,  32'h0000_0000, 1'b1, 32'h0, 1'b0, STATUS_OK,    17'd1282},
    {REQ_FREE,  16'h0000,  32'hFFFF_F000, 1'b1, 32'h0, 1'b0, STATUS_RANGE, 17'd1282},
    {REQ_MARK,  16'hFFFF,  32'hFFFF_FFFF, 1'b0, 52'h0},
    {REQ_ALLOC, 16'h5555,  32'hAAAA_AAAA, 1'b0, 52'h0},
    {REQ_QUERY, 16'h0500,  32'h5555_5555, 1'b0, 52'h0},
    {REQ_QUERY, 16'h0000,  32'h0000_0000, 1'b0, 52'h0}
  };

  logic clk;
  logic rst;

  bfa_stream_if #(.payload_t(req_item_t)) req_if ();
  bfa_stream_if #(.payload_t(res_item_t)) res_if ();

  bitmap_frame_allocator u_dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if)
  );

  // shadow of the usage bitmap; words below first_open_word are all full
  logic [WORD_BITS-1:0] shadow_map [NWORDS];
  logic [16:0]          shadow_used;
  int                   first_open_word;

  res_item_t   frame_replies_due [$];
  int          error_count = 0;
  int unsigned cycle_count = 0;
  logic [15:0] stall_pattern;
  int          stall_left = 0;
  int          stall_phase = 0;

  function automatic res_item_t predict_frame_reply(input req_item_t rq);
    res_item_t   reply;
    logic [31:0] frame;
    logic        found;
    int          w;
    int          b;
    reply = '0;
    reply.status = STATUS_OK;
    found = 1'b0;
    if (rq.req_type == REQ_ALLOC) begin
      for (w = first_open_word; w < NWORDS && !found; w++) begin
        if (shadow_map[w] == {WORD_BITS{1'b1}}) continue;
        for (b = 0; b < WORD_BITS; b++) begin
          frame = w * WORD_BITS + b;
          if (frame >= FRAMES) break;
          if (!shadow_map[w][b]) begin
            shadow_map[w][b] = 1'b1;
            shadow_used++;
            reply.alloc_address = 32'(frame * FRAME_BYTES);
            found = 1'b1;
            first_open_word = w;
            break;
          end
        end
      end
      if (!found) begin
        reply.status = STATUS_NO_FREE;
        first_open_word = NWORDS;
      end
    end else begin
      frame = (rq.req_type == REQ_FREE) ? rq.free_address / FRAME_BYTES
                                        : 32'(rq.frame_index);
      if (frame >= FRAMES) begin
        reply.status = STATUS_RANGE;
      end else begin
        w = frame / WORD_BITS;
        b = frame % WORD_BITS;
        case (rq.req_type)
          REQ_FREE: begin
            if (shadow_map[w][b]) begin
              shadow_map[w][b] = 1'b0;
              shadow_used--;
              if (w < first_open_word) first_open_word = w;
            end
          end
          REQ_MARK: begin
            if (!shadow_map[w][b]) begin
              shadow_map[w][b] = 1'b1;
              shadow_used++;
            end
          end
          default: begin
            reply.frame_free_flag = !shadow_map[w][b];
          end
        endcase
      end
    end
    reply.used_count = shadow_used;
    return reply;
  endfunction

  // mostly frames near the used region, where first fit keeps its work
  function automatic req_item_t random_request();
    req_item_t rq;
    int        roll;
    int        hot_top;
    int        pick;
    rq.frame_index  = 16'($urandom);
    rq.free_address = $urandom;
    hot_top = (shadow_used + 64 < FRAMES) ? shadow_used + 64 : FRAMES - 1;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    if (roll < 35) begin
      rq.req_type = REQ_ALLOC;
    end else if (roll < 60) begin
      rq.req_type = REQ_FREE;
      if (pick < 8) begin
        rq.free_address = 32'($urandom_range(0, hot_top)) * FRAME_BYTES
                          + $urandom_range(0, FRAME_BYTES - 1);
      end else if (pick == 8) begin
        rq.free_address = 32'($urandom_range(0, FRAMES - 1)) * FRAME_BYTES
                          + $urandom_range(0, FRAME_BYTES - 1);
      end
    end else begin
      rq.req_type = (roll < 75) ? REQ_MARK : REQ_QUERY;
      if (pick < 7) rq.frame_index = 16'($urandom_range(0, hot_top));
    end
    return rq;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue_request(input req_item_t rq, input logic typed,
                               input res_item_t want);
    res_item_t predicted;
    req_if.data  <= rq;
    req_if.valid <= 1'b1;
    do @(posedge clk); while (!req_if.ready);
    predicted = predict_frame_reply(rq);
    frame_replies_due.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic sender_gap(input int n);
    if (n > 0) begin
      req_if.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic run_random(input int count);
    int burst_left;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      issue_request(random_request(), 1'b0, '0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stalls follow a random 16-bit ready pattern, redrawn when stall_left runs out
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        stall_left = 32;
      end
      stall_left--;
      stall_phase = (stall_phase + 1) % 16;
      res_if.ready <= stall_pattern[stall_phase];
    end
  end

  always @(posedge clk) begin : check_results
    res_item_t want;
    res_item_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (frame_replies_due.size() == 0) begin
        report_mismatch("result with no request pending", 64'(got), 64'h0);
      end else begin
        want = frame_replies_due.pop_front();
        if (got.alloc_address !== want.alloc_address)
          report_mismatch("alloc_address", 64'(got.alloc_address),
                          64'(want.alloc_address));
        if (got.frame_free_flag !== want.frame_free_flag)
          report_mismatch("frame_free_flag", 64'(got.frame_free_flag),
                          64'(want.frame_free_flag));
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.used_count !== want.used_count)
          report_mismatch("used_count", 64'(got.used_count), 64'(want.used_count));
      end
    end
  end

  initial begin : stimulus
    req_item_t rq;
    int        reserved;
    rst          = 1'b1;
    req_if.valid = 1'b0;
    req_if.data  = '0;

    reserved = (RESERVED_FRAMES > FRAMES) ? FRAMES : RESERVED_FRAMES;
    for (int w = 0; w < NWORDS; w++) shadow_map[w] = '0;
    for (int f = 0; f < reserved; f++) shadow_map[f / WORD_BITS][f % WORD_BITS] = 1'b1;
    shadow_used     = 17'(reserved);
    first_open_word = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      rq.req_type     = dir_rows[i].kind;
      rq.frame_index  = dir_rows[i].idx;
      rq.free_address = dir_rows[i].addr;
      issue_request(rq, dir_rows[i].typed, dir_rows[i].want);
    end

    run_random(RANDOM_ITEMS);
    run_random(RANDOM_ITEMS);

    req_if.valid <= 1'b0;
    while (frame_replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bfa_pkg.sv
rtl/bfa_stream_if.sv
rtl/bfa_ram.sv
rtl/bitmap_frame_allocator.sv
test/bitmap_frame_allocator_tb.sv
